// ===== hw/rtl/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

   // Operation codes carried on the request channel
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4,
      OP_MAG  = 3'd5
   } op_type;

   // Quotient bits produced by the divider (integer part plus fraction, before rounding)
   localparam int QBITS = 33;
   // Partial remainder width: numerator magnitude shifted up to QBITS places
   localparam int REM_W = 64 + QBITS;
   // Number of iterative stages (one quotient bit each; root steps ride along)
   localparam int NSTAGE = QBITS;

   // Payload of one iterative stage
   typedef struct packed {
      op_type            op;
      logic              dz;
      logic [31:0]       fast_re;
      logic [31:0]       fast_im;
      logic              fast_ovf;
      logic [63:0]       den;
      logic              re_neg;
      logic              re_ovf;
      logic [REM_W-1:0]  re_rem;
      logic [QBITS-1:0]  re_q;
      logic              im_neg;
      logic              im_ovf;
      logic [REM_W-1:0]  im_rem;
      logic [QBITS-1:0]  im_q;
      logic [63:0]       sq_rem;
      logic [63:0]       sq_root;
   } iter_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cau_req_if.sv =====
`default_nettype none

interface cau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [31:0] a_re;
   logic signed [31:0] a_im;
   logic signed [31:0] b_re;
   logic signed [31:0] b_im;

   modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cau_rsp_if.sv =====
`default_nettype none

interface cau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_re;
   logic signed [31:0] res_im;
   logic               div_zero;
   logic               overflow;

   modport source (output valid, res_re, res_im, div_zero, overflow, input ready);
   modport sink   (input valid, res_re, res_im, div_zero, overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cau_iter_stage.sv =====
`default_nettype none

module cau_iter_stage #(
   parameter int DIV_BIT   = 0,
   parameter int SQRT_STEP = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cau_pkg::iter_type in_data,
   output logic              out_valid,
   output cau_pkg::iter_type out_data
);
   import cau_pkg::*;

   logic             valid_ff;
   iter_type         data_ff;
   iter_type         data_in;
   logic [REM_W-1:0] den_sh;
   logic [63:0]      sq_rem_nx;
   logic [63:0]      sq_root_nx;

   assign den_sh = {{(REM_W-64){1'b0}}, in_data.den} << DIV_BIT;

   // Square root step: try to set one root bit
   if (SQRT_STEP >= 0) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (2 * SQRT_STEP);
      logic [63:0] trial;
      assign trial = in_data.sq_root + SQ_BIT;
      always_comb begin
         if (in_data.sq_rem >= trial) begin
            sq_rem_nx  = in_data.sq_rem - trial;
            sq_root_nx = (in_data.sq_root >> 1) + SQ_BIT;
         end else begin
            sq_rem_nx  = in_data.sq_rem;
            sq_root_nx = in_data.sq_root >> 1;
         end
      end
   end else begin : g_nosqrt
      assign sq_rem_nx  = in_data.sq_rem;
      assign sq_root_nx = in_data.sq_root;
   end

   // Restoring division step on both result parts
   always_comb begin
      data_in         = in_data;
      data_in.sq_rem  = sq_rem_nx;
      data_in.sq_root = sq_root_nx;
      if (in_data.re_rem >= den_sh) begin
         data_in.re_rem        = in_data.re_rem - den_sh;
         data_in.re_q[DIV_BIT] = 1'b1;
      end
      if (in_data.im_rem >= den_sh) begin
         data_in.im_rem        = in_data.im_rem - den_sh;
         data_in.im_q[DIV_BIT] = 1'b1;
      end
   end

   // Advance the stage when the pipeline moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
`default_nettype none

// Channel  Direction  Contents
// req      in         operation, a_re, a_im, b_re, b_im
// rsp      out        res_re, res_im, div_zero, overflow
//
// One transaction enters per cycle unless a stalled response holds the pipeline.
// The divider has 33 quotient-bit stages, with the square root
// sharing those stages, after five stages of input, multiply, sum, sign and setup.
// Reset clears only the valid bits; no state is carried between transactions.
// A stalled response holds the whole pipeline; nothing is dropped or repeated.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   cau_req_if.sink  req_chan,
   cau_rsp_if.source rsp_chan
);
   import cau_pkg::*;

   localparam logic [64:0] HALF = 65'd1 << (FRAC_BITS - 1);

   // Saturate a wide signed value to 32 bits; top bit of the result is overflow
   function automatic logic [32:0] sat_wide(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   logic en;

   // Stage 0: input registers
   logic               v0_ff;
   op_type             op0_ff;
   logic signed [31:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;

   // Stage 1: products and fast results
   logic               v1_ff;
   op_type             op1_ff;
   logic signed [63:0] p_ff [0:5];
   logic signed [63:0] p_in [0:5];
   logic [31:0]        fre1_ff, fim1_ff, fre1_in, fim1_in;
   logic               fovf1_ff, fovf1_in, dz1_ff, dz1_in;
   logic signed [31:0] mbr, mbi;

   // Stage 2: sums
   logic               v2_ff;
   op_type             op2_ff;
   logic signed [65:0] sre2_ff, sim2_ff, sre2_in, sim2_in;
   logic [63:0]        den2_ff;
   logic [31:0]        fre2_ff, fim2_ff;
   logic               fovf2_ff, dz2_ff;

   // Stage 3: sign and magnitude, multiply result
   logic               v3_ff;
   op_type             op3_ff;
   logic               nre3_ff, nim3_ff;
   logic [63:0]        mre3_ff, mim3_ff, mre3_in, mim3_in;
   logic [63:0]        den3_ff;
   logic [31:0]        fre3_ff, fim3_ff, fre3_in, fim3_in;
   logic               fovf3_ff, fovf3_in, dz3_ff;

   // Stage 4 and iterative stages
   logic               st_valid [0:NSTAGE];
   iter_type           st_data  [0:NSTAGE];
   logic               v4_ff;
   iter_type           st4_ff, st4_in;

   // Output register
   logic               ov_ff;
   logic [31:0]        ore_ff, oim_ff, ore_in, oim_in;
   logic               odz_ff, oovf_ff, odz_in, oovf_in;

   assign en             = !ov_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Valid bits advance with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_chan.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         ov_ff <= st_valid[NSTAGE];
      end
   end

   // Stage 1: route operands for magnitude, form fast results
   assign mbr = (op0_ff == OP_MAG) ? ar0_ff : br0_ff;
   assign mbi = (op0_ff == OP_MAG) ? ai0_ff : bi0_ff;

   always_comb begin
      logic [32:0] sr, si;
      p_in[0] = ar0_ff * mbr;
      p_in[1] = ai0_ff * mbi;
      p_in[2] = ar0_ff * bi0_ff;
      p_in[3] = ai0_ff * br0_ff;
      p_in[4] = br0_ff * br0_ff;
      p_in[5] = bi0_ff * bi0_ff;
      sr       = '0;
      si       = '0;
      dz1_in   = 1'b0;
      case (op0_ff)
         OP_ADD: begin
            sr = sat_wide(66'(ar0_ff) + 66'(br0_ff));
            si = sat_wide(66'(ai0_ff) + 66'(bi0_ff));
         end
         OP_SUB: begin
            sr = sat_wide(66'(ar0_ff) - 66'(br0_ff));
            si = sat_wide(66'(ai0_ff) - 66'(bi0_ff));
         end
         OP_CONJ: begin
            sr = {1'b0, ar0_ff};
            si = sat_wide(-66'(ai0_ff));
         end
         OP_DIV: begin
            if (br0_ff == 32'sd0 && bi0_ff == 32'sd0) begin
               dz1_in = 1'b1;
               sr     = {1'b0, ar0_ff};
               si     = {1'b0, ai0_ff};
            end
         end
         default: begin
         end
      endcase
      fre1_in  = sr[31:0];
      fim1_in  = si[31:0];
      fovf1_in = sr[32] | si[32];
   end

   // Stage 2: combine products per operation
   always_comb begin
      sre2_in = '0;
      sim2_in = '0;
      case (op1_ff)
         OP_MUL: begin
            sre2_in = 66'(p_ff[0]) - 66'(p_ff[1]);
            sim2_in = 66'(p_ff[2]) + 66'(p_ff[3]);
         end
         OP_DIV: begin
            sre2_in = 66'(p_ff[0]) + 66'(p_ff[1]);
            sim2_in = 66'(p_ff[3]) - 66'(p_ff[2]);
         end
         OP_MAG: begin
            sre2_in = 66'(p_ff[0]) + 66'(p_ff[1]);
         end
         default: begin
         end
      endcase
   end

   // Stage 3: magnitudes, round and saturate the product
   always_comb begin
      logic signed [65:0] are, aim, vre, vim;
      logic [64:0]        rre, rim;
      logic [32:0]        sr, si;
      are     = sre2_ff[65] ? -sre2_ff : sre2_ff;
      aim     = sim2_ff[65] ? -sim2_ff : sim2_ff;
      mre3_in = are[63:0];
      mim3_in = aim[63:0];
      rre     = ({1'b0, mre3_in} + HALF) >> FRAC_BITS;
      rim     = ({1'b0, mim3_in} + HALF) >> FRAC_BITS;
      vre     = sre2_ff[65] ? -$signed({1'b0, rre}) : $signed({1'b0, rre});
      vim     = sim2_ff[65] ? -$signed({1'b0, rim}) : $signed({1'b0, rim});
      sr      = sat_wide(vre);
      si      = sat_wide(vim);
      if (op2_ff == OP_MUL) begin
         fre3_in  = sr[31:0];
         fim3_in  = si[31:0];
         fovf3_in = sr[32] | si[32];
      end else begin
         fre3_in  = fre2_ff;
         fim3_in  = fim2_ff;
         fovf3_in = fovf2_ff;
      end
   end

   // Stage 4: scale numerators, check quotient range, seed the root
   always_comb begin
      logic [REM_W-1:0] den_top;
      den_top          = {den3_ff, {QBITS{1'b0}}};
      st4_in.op        = op3_ff;
      st4_in.dz        = dz3_ff;
      st4_in.fast_re   = fre3_ff;
      st4_in.fast_im   = fim3_ff;
      st4_in.fast_ovf  = fovf3_ff;
      st4_in.den       = den3_ff;
      st4_in.re_neg    = nre3_ff;
      st4_in.re_rem    = {{QBITS{1'b0}}, mre3_ff} << FRAC_BITS;
      st4_in.re_ovf    = st4_in.re_rem >= den_top;
      st4_in.re_q      = '0;
      st4_in.im_neg    = nim3_ff;
      st4_in.im_rem    = {{QBITS{1'b0}}, mim3_ff} << FRAC_BITS;
      st4_in.im_ovf    = st4_in.im_rem >= den_top;
      st4_in.im_q      = '0;
      st4_in.sq_rem    = mre3_ff;
      st4_in.sq_root   = '0;
   end

   // Payload registers for the front stages
   always_ff @(posedge clock) begin
      if (en) begin
         op0_ff   <= op_type'(req_chan.operation);
         ar0_ff   <= req_chan.a_re;
         ai0_ff   <= req_chan.a_im;
         br0_ff   <= req_chan.b_re;
         bi0_ff   <= req_chan.b_im;

         op1_ff   <= op0_ff;
         for (int k = 0; k < 6; k++) begin
            p_ff[k] <= p_in[k];
         end
         fre1_ff  <= fre1_in;
         fim1_ff  <= fim1_in;
         fovf1_ff <= fovf1_in;
         dz1_ff   <= dz1_in;

         op2_ff   <= op1_ff;
         sre2_ff  <= sre2_in;
         sim2_ff  <= sim2_in;
         den2_ff  <= p_ff[4] + p_ff[5];
         fre2_ff  <= fre1_ff;
         fim2_ff  <= fim1_ff;
         fovf2_ff <= fovf1_ff;
         dz2_ff   <= dz1_ff;

         op3_ff   <= op2_ff;
         nre3_ff  <= sre2_ff[65];
         nim3_ff  <= sim2_ff[65];
         mre3_ff  <= mre3_in;
         mim3_ff  <= mim3_in;
         den3_ff  <= den2_ff;
         fre3_ff  <= fre3_in;
         fim3_ff  <= fim3_in;
         fovf3_ff <= fovf3_in;
         dz3_ff   <= dz2_ff;

         st4_ff   <= st4_in;

         ore_ff   <= ore_in;
         oim_ff   <= oim_in;
         odz_ff   <= odz_in;
         oovf_ff  <= oovf_in;
      end
   end

   // Iterative divider and square root stages
   assign st_valid[0] = v4_ff;
   assign st_data[0]  = st4_ff;

   for (genvar j = 0; j < NSTAGE; j++) begin : g_iter
      cau_iter_stage #(
         .DIV_BIT   (QBITS - 1 - j),
         .SQRT_STEP (QBITS - 2 - j)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (st_valid[j]),
         .in_data   (st_data[j]),
         .out_valid (st_valid[j+1]),
         .out_data  (st_data[j+1])
      );
   end

   // Final rounding and selection
   always_comb begin
      iter_type           f;
      logic [QBITS:0]     qre, qim;
      logic signed [65:0] vre, vim;
      logic [32:0]        sr, si;
      f       = st_data[NSTAGE];
      qre     = {1'b0, f.re_q} +
                (QBITS+1)'({f.re_rem[63:0], 1'b0} >= {1'b0, f.den});
      qim     = {1'b0, f.im_q} +
                (QBITS+1)'({f.im_rem[63:0], 1'b0} >= {1'b0, f.den});
      vre     = f.re_ovf ? 66'sh1_0000_0000 : $signed(66'(qre));
      vim     = f.im_ovf ? 66'sh1_0000_0000 : $signed(66'(qim));
      vre     = f.re_neg ? -vre : vre;
      vim     = f.im_neg ? -vim : vim;
      sr      = '0;
      si      = '0;
      ore_in  = '0;
      oim_in  = '0;
      odz_in  = 1'b0;
      oovf_in = 1'b0;
      case (f.op)
         OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
            ore_in  = f.fast_re;
            oim_in  = f.fast_im;
            oovf_in = f.fast_ovf;
         end
         OP_DIV: begin
            if (f.dz) begin
               ore_in = f.fast_re;
               oim_in = f.fast_im;
               odz_in = 1'b1;
            end else begin
               sr      = sat_wide(vre);
               si      = sat_wide(vim);
               ore_in  = sr[31:0];
               oim_in  = si[31:0];
               oovf_in = sr[32] | si[32];
            end
         end
         OP_MAG: begin
            sr      = sat_wide($signed({2'b0, f.sq_root}) +
                               66'(f.sq_rem > f.sq_root));
            ore_in  = sr[31:0];
            oovf_in = sr[32];
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid    = ov_ff;
   assign rsp_chan.res_re   = ore_ff;
   assign rsp_chan.res_im   = oim_ff;
   assign rsp_chan.div_zero = odz_ff;
   assign rsp_chan.overflow = oovf_ff;

endmodule

`default_nettype wire
